// ----- sv/fsu_pkg.sv -----
// fsu_pkg: shared types and constants for the falling sand grid update block.
// Field widths, operation and material codes, controller/datapath command and status.
// No dependencies.
package fsu_pkg;

    localparam int OP_W      = 2;
    localparam int COORD_W   = 6;
    localparam int MAT_W     = 3;
    localparam int MASK_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;
    localparam int NB_COUNT  = 5;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_SWEEP = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    localparam logic [MAT_W-1:0] CODE_EMPTY   = 3'd0;
    localparam logic [MAT_W-1:0] CODE_BLOCKER = 3'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_SOLID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUID = 1'd1;

    localparam logic [MASK_W-1:0] SOLID_RST = 8'd14;
    localparam logic [MASK_W-1:0] FLUID_RST = 8'd16;

    // neighbours of the cell under the sweep
    typedef enum logic [2:0] {NB_DN, NB_DL, NB_DR, NB_LF, NB_RT} nbr_t;

    typedef enum logic [1:0] {RS_SELF, RS_NB, RS_OP} rd_src_t;

    typedef struct packed {
        logic    op_load;
        logic    scan_rst;
        logic    scan_adv;
        logic    clr_wr;
        logic    rd_en;
        rd_src_t rd_src;
        nbr_t    rd_nb;
        logic    cap_self;
        logic    cap_nb;
        nbr_t    cap_sel;
        logic    wr_op;
        logic    wr_tgt;
        logic    wr_src;
        logic    out_load;
    } fsu_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            self_act;
        logic            move;
        logic            scan_last;
        logic            out_busy;
    } fsu_sts_t;

endpackage

// ----- sv/falling_sand_grid_update.sv -----
// falling_sand_grid_update: top level of the falling sand grid block.
// Joins the controller fsu_ctrl and the datapath fsu_dp; depends on fsu_pkg.
//
// channel   direction  handshake             contents
// s_        in         s_tvalid/s_tready     tdata: cell_x, cell_y, material_in; tuser: op
// m_        out        m_tvalid/m_tready     tdata: material_out; tuser: done_op
// cfg_      in         cfg_wr_en             cfg_index 0 solid_mask, 1 fluid_mask
//
// Write, read and unused ops run through the execute and done states.
// A sweep reads each cell and, for a cell that holds a moving grain, its five neighbours
// one by one through the single read port of the grid memory; a grain that moves is written
// to its target and its source cell. After reset a clearing pass empties all cells of the grid;
// no word is accepted during it. One word is worked at a time; the next one is
// accepted while the previous result word still waits on m_tready.
module falling_sand_grid_update #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [5:0] cell_x, [11:6] cell_y, [14:12] material_in, [15] zero
    input  logic [fsu_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] op
    input  logic [fsu_pkg::OP_W-1:0]        s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] material_out, [7:3] zero
    output logic [fsu_pkg::M_TDATA_W-1:0]   m_tdata,
    // [1:0] done_op
    output logic [fsu_pkg::OP_W-1:0]        m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [fsu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsu_pkg::MASK_W-1:0]      cfg_wdata
);

    fsu_pkg::fsu_cmd_t cmd;
    fsu_pkg::fsu_sts_t sts;

    fsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fsu_dp #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- sv/fsu_dp.sv -----
// fsu_dp: datapath of the falling sand grid update block.
// Holds the grid memory, scan counters, neighbour registers, masks and output word.
// Depends on fsu_pkg.
module fsu_dp #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  fsu_pkg::fsu_cmd_t               cmd,
    output fsu_pkg::fsu_sts_t               sts,
    input  logic [fsu_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [fsu_pkg::OP_W-1:0]        s_tuser,
    input  logic                            cfg_wr_en,
    input  logic [fsu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsu_pkg::MASK_W-1:0]      cfg_wdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fsu_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [fsu_pkg::OP_W-1:0]        m_tuser
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] H_A    = AW'(GRID_HEIGHT);
    localparam logic [AW-1:0] ONE_A  = AW'(1);
    localparam logic [XW-1:0] X_LAST = XW'(GRID_WIDTH - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(GRID_HEIGHT - 1);

    logic [fsu_pkg::MAT_W-1:0] grid_mem [CELLS];
    logic [fsu_pkg::MAT_W-1:0] rd_q_reg;

    logic [AW-1:0] scan_addr_reg;
    logic [XW-1:0] scan_x_reg;
    logic [YW-1:0] scan_y_reg;

    logic [fsu_pkg::MASK_W-1:0] solid_mask_reg;
    logic [fsu_pkg::MASK_W-1:0] fluid_mask_reg;
    logic                       side_reg;

    logic [fsu_pkg::OP_W-1:0]   op_reg;
    logic [fsu_pkg::MAT_W-1:0]  op_mat_reg;
    logic [AW-1:0]              op_addr_reg;
    logic                       op_in_reg;

    logic [fsu_pkg::MAT_W-1:0]  self_code_reg;
    logic [fsu_pkg::MAT_W-1:0]  nb_code_reg [fsu_pkg::NB_COUNT];
    logic [fsu_pkg::MAT_W-1:0]  fill_reg;

    logic                       m_tvalid_reg;
    logic [fsu_pkg::MAT_W-1:0]  m_mat_reg;
    logic [fsu_pkg::OP_W-1:0]   m_op_reg;

    logic [fsu_pkg::COORD_W-1:0] in_x;
    logic [fsu_pkg::COORD_W-1:0] in_y;
    logic [fsu_pkg::MAT_W-1:0]   in_mat;

    logic                x_last, y_last, x_zero, y_zero;
    logic [AW-1:0]       nb_addr  [fsu_pkg::NB_COUNT];
    logic                nb_in    [fsu_pkg::NB_COUNT];
    logic                nb_solid [fsu_pkg::NB_COUNT];
    logic                nb_fluid [fsu_pkg::NB_COUNT];
    logic                dl, dn, dr, lf, rt;
    logic                dec_move, dec_alt;
    fsu_pkg::nbr_t       dec_tgt;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [fsu_pkg::MAT_W-1:0] wr_data, res_mat;
    logic                wr_en;

    assign in_x   = s_tdata[5:0];
    assign in_y   = s_tdata[11:6];
    assign in_mat = s_tdata[14:12];

    assign x_last = (scan_x_reg == X_LAST);
    assign y_last = (scan_y_reg == Y_LAST);
    assign x_zero = (scan_x_reg == '0);
    assign y_zero = (scan_y_reg == '0);

    always_comb begin
        nb_in[fsu_pkg::NB_DN] = !y_zero;
        nb_in[fsu_pkg::NB_DL] = !x_zero && !y_zero;
        nb_in[fsu_pkg::NB_DR] = !x_last && !y_zero;
        nb_in[fsu_pkg::NB_LF] = !x_zero;
        nb_in[fsu_pkg::NB_RT] = !x_last;
        nb_addr[fsu_pkg::NB_DN] = scan_addr_reg - ONE_A;
        nb_addr[fsu_pkg::NB_DL] = scan_addr_reg - H_A - ONE_A;
        nb_addr[fsu_pkg::NB_DR] = scan_addr_reg + H_A - ONE_A;
        nb_addr[fsu_pkg::NB_LF] = scan_addr_reg - H_A;
        nb_addr[fsu_pkg::NB_RT] = scan_addr_reg + H_A;
        for (int k = 0; k < fsu_pkg::NB_COUNT; k++) begin
            if (!nb_in[k]) begin
                nb_addr[k] = scan_addr_reg;
            end
            nb_solid[k] = !nb_in[k] || solid_mask_reg[nb_code_reg[k]];
            nb_fluid[k] = nb_in[k] && fluid_mask_reg[nb_code_reg[k]];
        end
    end

    assign dl = nb_solid[fsu_pkg::NB_DL];
    assign dn = nb_solid[fsu_pkg::NB_DN];
    assign dr = nb_solid[fsu_pkg::NB_DR];
    assign lf = nb_solid[fsu_pkg::NB_LF];
    assign rt = nb_solid[fsu_pkg::NB_RT];

    always_comb begin
        dec_move = 1'b1;
        dec_alt  = 1'b0;
        dec_tgt  = fsu_pkg::NB_DN;
        priority if (dl && dn && dr) begin
            dec_move = 1'b0;
        end else if (dl && dn && !dr && !rt) begin
            dec_tgt = fsu_pkg::NB_DR;
        end else if (dr && dn && !dl && !lf) begin
            dec_tgt = fsu_pkg::NB_DL;
        end else if (dn && !dl && !dr && !lf && !rt) begin
            dec_alt = 1'b1;
            dec_tgt = side_reg ? fsu_pkg::NB_DR : fsu_pkg::NB_DL;
        end else if (!dn) begin
            dec_tgt = fsu_pkg::NB_DN;
        end else begin
            dec_move = 1'b0;
        end
    end

    always_comb begin
        unique case (cmd.rd_src)
            fsu_pkg::RS_SELF: rd_addr = scan_addr_reg;
            fsu_pkg::RS_NB:   rd_addr = nb_addr[cmd.rd_nb];
            fsu_pkg::RS_OP:   rd_addr = op_addr_reg;
            default:          rd_addr = scan_addr_reg;
        endcase
    end

    assign wr_en = cmd.clr_wr || cmd.wr_tgt || cmd.wr_src || (cmd.wr_op && op_in_reg);

    always_comb begin
        priority if (cmd.clr_wr) begin
            wr_addr = scan_addr_reg;
            wr_data = fsu_pkg::CODE_EMPTY;
        end else if (cmd.wr_tgt) begin
            wr_addr = nb_addr[dec_tgt];
            wr_data = self_code_reg;
        end else if (cmd.wr_src) begin
            wr_addr = scan_addr_reg;
            wr_data = fill_reg;
        end else begin
            wr_addr = op_addr_reg;
            wr_data = op_mat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_q_reg <= grid_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg  <= '0;
            scan_x_reg     <= '0;
            scan_y_reg     <= '0;
            solid_mask_reg <= fsu_pkg::SOLID_RST;
            fluid_mask_reg <= fsu_pkg::FLUID_RST;
            side_reg       <= 1'b1;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.scan_rst) begin
                scan_addr_reg <= '0;
                scan_x_reg    <= '0;
                scan_y_reg    <= '0;
            end else if (cmd.scan_adv) begin
                scan_addr_reg <= scan_addr_reg + ONE_A;
                if (y_last) begin
                    scan_y_reg <= '0;
                    scan_x_reg <= scan_x_reg + XW'(1);
                end else begin
                    scan_y_reg <= scan_y_reg + YW'(1);
                end
            end
            if (cfg_wr_en && cfg_index == fsu_pkg::CFG_SOLID) begin
                solid_mask_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_index == fsu_pkg::CFG_FLUID) begin
                fluid_mask_reg <= cfg_wdata;
            end
            if (cmd.wr_tgt && dec_alt) begin
                side_reg <= !side_reg;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign res_mat = (op_reg != fsu_pkg::OP_READ) ? fsu_pkg::CODE_EMPTY :
                     (op_in_reg ? rd_q_reg : fsu_pkg::CODE_BLOCKER);

    always_ff @(posedge aclk) begin
        if (cmd.op_load) begin
            op_reg      <= s_tuser;
            op_mat_reg  <= in_mat;
            op_in_reg   <= (32'(in_x) < GRID_WIDTH) && (32'(in_y) < GRID_HEIGHT);
            op_addr_reg <= AW'(in_x) * H_A + AW'(in_y);
        end
        if (cmd.cap_self) begin
            self_code_reg <= rd_q_reg;
        end
        if (cmd.cap_nb) begin
            nb_code_reg[cmd.cap_sel] <= rd_q_reg;
        end
        if (cmd.wr_tgt) begin
            fill_reg <= nb_fluid[dec_tgt] ? nb_code_reg[dec_tgt] : fsu_pkg::CODE_EMPTY;
        end
        if (cmd.out_load) begin
            m_mat_reg <= res_mat;
            m_op_reg  <= op_reg;
        end
    end

    assign sts.op        = op_reg;
    assign sts.self_act  = solid_mask_reg[rd_q_reg] && (rd_q_reg != fsu_pkg::CODE_BLOCKER);
    assign sts.move      = dec_move;
    assign sts.scan_last = x_last && y_last;
    assign sts.out_busy  = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(fsu_pkg::M_TDATA_W - fsu_pkg::MAT_W){1'b0}}, m_mat_reg};
    assign m_tuser  = m_op_reg;

`ifndef ASSERT_OFF
    a_tgt_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_tgt |-> nb_in[dec_tgt] && dec_move)
        else $error("move target outside grid");

    a_src_after_tgt: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_src |-> $past(cmd.wr_tgt))
        else $error("source write without target write");

    a_side_toggle: assert property (@(posedge aclk)
        aresetn && $past(aresetn) && (side_reg != $past(side_reg)) |-> $past(cmd.wr_tgt))
        else $error("side choice changed outside a move");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !sts.out_busy)
        else $error("result word overwritten");
`endif

endmodule

// ----- sv/fsu_ctrl.sv -----
// fsu_ctrl: controller of the falling sand grid update block.
// Sequences clearing, cell access and the sweep through the datapath.
// Depends on fsu_pkg.
module fsu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  fsu_pkg::fsu_sts_t sts,
    output fsu_pkg::fsu_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_SW_RD, S_SW_SELF, S_SW_NB, S_SW_DEC, S_SW_WS, S_DONE
    } state_t;

    state_t        state_reg, state_next;
    fsu_pkg::nbr_t nb_reg, nb_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        nb_next    = nb_reg;
        cmd        = '0;
        cmd.rd_src = fsu_pkg::RS_SELF;
        cmd.rd_nb  = fsu_pkg::NB_DN;
        cmd.cap_sel = nb_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.scan_last) begin
                    cmd.scan_rst = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    cmd.scan_adv = 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op_load = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (sts.op)
                    fsu_pkg::OP_WRITE: begin
                        cmd.wr_op  = 1'b1;
                        state_next = S_DONE;
                    end
                    fsu_pkg::OP_READ: begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_src = fsu_pkg::RS_OP;
                        state_next = S_DONE;
                    end
                    fsu_pkg::OP_SWEEP: state_next = S_SW_RD;
                    default:           state_next = S_DONE;
                endcase
            end
            S_SW_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_SW_SELF;
            end
            S_SW_SELF: begin
                cmd.cap_self = 1'b1;
                if (sts.self_act) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = fsu_pkg::RS_NB;
                    cmd.rd_nb  = fsu_pkg::NB_DN;
                    nb_next    = fsu_pkg::NB_DN;
                    state_next = S_SW_NB;
                end else if (sts.scan_last) begin
                    cmd.scan_rst = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.scan_adv = 1'b1;
                    state_next   = S_SW_RD;
                end
            end
            S_SW_NB: begin
                cmd.cap_nb = 1'b1;
                if (nb_reg == fsu_pkg::NB_RT) begin
                    state_next = S_SW_DEC;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = fsu_pkg::RS_NB;
                    cmd.rd_nb  = fsu_pkg::nbr_t'(nb_reg + 3'd1);
                    nb_next    = fsu_pkg::nbr_t'(nb_reg + 3'd1);
                end
            end
            S_SW_DEC: begin
                if (sts.move) begin
                    cmd.wr_tgt = 1'b1;
                    state_next = S_SW_WS;
                end else if (sts.scan_last) begin
                    cmd.scan_rst = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.scan_adv = 1'b1;
                    state_next   = S_SW_RD;
                end
            end
            S_SW_WS: begin
                cmd.wr_src = 1'b1;
                if (sts.scan_last) begin
                    cmd.scan_rst = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.scan_adv = 1'b1;
                    state_next   = S_SW_RD;
                end
            end
            S_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            nb_reg    <= fsu_pkg::NB_DN;
        end else begin
            state_reg <= state_next;
            nb_reg    <= nb_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_EXEC)
        else $error("accepted word not executed");

    a_scan_home: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !cmd.scan_adv && !cmd.wr_tgt && !cmd.clr_wr)
        else $error("grid activity while idle");

    a_dec_after_nb: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SW_DEC |-> $past(state_reg) == S_SW_NB && $past(nb_reg) == fsu_pkg::NB_RT)
        else $error("decision before all neighbours captured");
`endif

endmodule

// ----- bench/fsu_checker.sv -----
`timescale 1ns / 1ps
// fsu_checker: watches the s_/m_/cfg_ channels of falling_sand_grid_update, keeps its own
// copy of the grid and masks, predicts each result word and compares. Depends on fsu_pkg.
module fsu_checker #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fsu_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [fsu_pkg::OP_W-1:0]        s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fsu_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [fsu_pkg::OP_W-1:0]        m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [fsu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsu_pkg::MASK_W-1:0]      cfg_wdata,
    output int                              fail_count,
    output int                              n_outstanding
);

    typedef struct packed {
        logic [fsu_pkg::MAT_W-1:0] mat;
        logic [fsu_pkg::OP_W-1:0]  op;
    } cell_word_t;

    logic [fsu_pkg::MAT_W-1:0]  grid_copy [0:GRID_W*GRID_H-1];
    logic                       side_right;
    logic [fsu_pkg::MASK_W-1:0] solid_bits;
    logic [fsu_pkg::MASK_W-1:0] fluid_bits;
    cell_word_t                 expected_words [$];

    function automatic bit on_grid(int x, int y);
        return x >= 0 && y >= 0 && x < GRID_W && y < GRID_H;
    endfunction

    function automatic bit cell_solid(int x, int y);
        if (!on_grid(x, y))
            return 1'b1;
        return solid_bits[grid_copy[x*GRID_H + y]];
    endfunction

    function automatic bit cell_fluid(int x, int y);
        if (!on_grid(x, y))
            return 1'b0;
        return fluid_bits[grid_copy[x*GRID_H + y]];
    endfunction

    function automatic void shift_grain(int x, int y, int tx, int ty);
        int                        src;
        int                        dst;
        bit                        swap;
        logic [fsu_pkg::MAT_W-1:0] held;
        src  = x*GRID_H + y;
        dst  = tx*GRID_H + ty;
        swap = cell_fluid(tx, ty);
        held = grid_copy[dst];
        grid_copy[dst] = grid_copy[src];
        grid_copy[src] = swap ? held : fsu_pkg::CODE_EMPTY;
    endfunction

    function automatic void settle_grain(int x, int y);
        bit dl;
        bit dn;
        bit dr;
        bit lf;
        bit rt;
        dl = cell_solid(x - 1, y - 1);
        dn = cell_solid(x, y - 1);
        dr = cell_solid(x + 1, y - 1);
        lf = cell_solid(x - 1, y);
        rt = cell_solid(x + 1, y);
        if (dl && dn && dr)
            return;
        if (dl && dn && !dr && !rt) begin
            shift_grain(x, y, x + 1, y - 1);
        end else if (dr && dn && !dl && !lf) begin
            shift_grain(x, y, x - 1, y - 1);
        end else if (dn && !dl && !dr && !lf && !rt) begin
            shift_grain(x, y, side_right ? x + 1 : x - 1, y - 1);
            side_right = !side_right;
        end else if (!dn) begin
            shift_grain(x, y, x, y - 1);
        end
    endfunction

    function automatic void sweep_grid();
        logic [fsu_pkg::MAT_W-1:0] code;
        for (int x = 0; x < GRID_W; x++) begin
            for (int y = 0; y < GRID_H; y++) begin
                code = grid_copy[x*GRID_H + y];
                if (solid_bits[code] && code != fsu_pkg::CODE_BLOCKER)
                    settle_grain(x, y);
            end
        end
    endfunction

    always @(posedge aclk) begin : watch
        cell_word_t got;
        cell_word_t want;
        int         cx;
        int         cy;
        if (!aresetn) begin
            for (int i = 0; i < GRID_W*GRID_H; i++)
                grid_copy[i] = fsu_pkg::CODE_EMPTY;
            side_right = 1'b1;
            solid_bits = fsu_pkg::SOLID_RST;
            fluid_bits = fsu_pkg::FLUID_RST;
            expected_words.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    fsu_pkg::CFG_SOLID: solid_bits = cfg_wdata;
                    fsu_pkg::CFG_FLUID: fluid_bits = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.mat = m_tdata[fsu_pkg::MAT_W-1:0];
                got.op  = m_tuser;
                if (expected_words.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none, got %0d / %0d",
                             $time, got.mat, got.op);
                end else begin
                    want = expected_words.pop_front();
                    if (got.mat !== want.mat) begin
                        fail_count++;
                        $display("%0t: material_out expected %0d, got %0d",
                                 $time, want.mat, got.mat);
                    end
                    if (got.op !== want.op) begin
                        fail_count++;
                        $display("%0t: done_op expected %0d, got %0d", $time, want.op, got.op);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                cx = int'(s_tdata[fsu_pkg::COORD_W-1:0]);
                cy = int'(s_tdata[2*fsu_pkg::COORD_W-1:fsu_pkg::COORD_W]);
                want.op  = s_tuser;
                want.mat = fsu_pkg::CODE_EMPTY;
                case (s_tuser)
                    fsu_pkg::OP_WRITE:
                        if (on_grid(cx, cy))
                            grid_copy[cx*GRID_H + cy] =
                                s_tdata[2*fsu_pkg::COORD_W+fsu_pkg::MAT_W-1:
                                        2*fsu_pkg::COORD_W];
                    fsu_pkg::OP_READ:
                        want.mat = on_grid(cx, cy) ? grid_copy[cx*GRID_H + cy] :
                                                     fsu_pkg::CODE_BLOCKER;
                    fsu_pkg::OP_SWEEP:
                        sweep_grid();
                    default: ;
                endcase
                expected_words.push_back(want);
            end
        end
        n_outstanding = expected_words.size();
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for falling_sand_grid_update: directed cell writes, reads
// and sweeps, then random sand scenes under several mask settings. Uses fsu_pkg, fsu_checker.
module tb_top;

    localparam int GRID_W     = 64;
    localparam int GRID_H     = 64;
    localparam int QUIET_MAX  = 200000;
    localparam int HOLD_LEN   = 300;

    localparam logic [fsu_pkg::MAT_W-1:0] MAT_SAND     = 3'd2;
    localparam logic [fsu_pkg::MAT_W-1:0] MAT_RED_SAND = 3'd3;
    localparam logic [fsu_pkg::MAT_W-1:0] MAT_WATER    = 3'd4;
    localparam logic [fsu_pkg::MAT_W-1:0] MAT_SPARE    = 3'd7;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [fsu_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [fsu_pkg::OP_W-1:0]       s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [fsu_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [fsu_pkg::OP_W-1:0]       m_tuser;
    logic                           cfg_wr_en;
    logic [fsu_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fsu_pkg::MASK_W-1:0]     cfg_wdata;

    int fail_count;
    int n_outstanding;
    int words_sent;
    int hold_asked;
    int hold_done;
    bit tx_idle;

    falling_sand_grid_update #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fsu_checker #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .n_outstanding (n_outstanding)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > GRID_W - 1)
            return GRID_W - 1;
        return v;
    endfunction

    task automatic send_word(input logic [fsu_pkg::OP_W-1:0] op, input int x, input int y,
                             input logic [fsu_pkg::MAT_W-1:0] mat);
        int gap;
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {1'b0, mat, y[fsu_pkg::COORD_W-1:0], x[fsu_pkg::COORD_W-1:0]};
        s_tuser  = op;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic write_reg(input logic [fsu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fsu_pkg::MASK_W-1:0] val);
        cfg_index = idx;
        cfg_wdata = val;
        cfg_wr_en = 1'b1;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (n_outstanding != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // a small pile of grains around one spot, swept, read back, then at times an unused op or a write
    task automatic run_scene(input int sweeps_max);
        int                        bx;
        int                        by;
        int                        n;
        logic [fsu_pkg::MAT_W-1:0] mat;
        case ($urandom_range(0, 3))
            0: bx = 0;
            1: bx = GRID_W - 1;
            default: bx = $urandom_range(0, GRID_W - 1);
        endcase
        by = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : $urandom_range(0, GRID_H - 1);
        n = $urandom_range(3, 8);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mat = MAT_SAND;
                4:          mat = MAT_RED_SAND;
                5, 6:       mat = MAT_WATER;
                7:          mat = fsu_pkg::CODE_BLOCKER;
                8:          mat = fsu_pkg::CODE_EMPTY;
                default:    mat = 3'($urandom_range(0, 7));
            endcase
            send_word(fsu_pkg::OP_WRITE, clamp_coord(bx + $urandom_range(0, 4) - 2),
                      clamp_coord(by + $urandom_range(0, 5)), mat);
        end
        n = $urandom_range(1, sweeps_max);
        repeat (n)
            send_word(fsu_pkg::OP_SWEEP, $urandom_range(0, 63), $urandom_range(0, 63),
                      3'($urandom_range(0, 7)));
        n = $urandom_range(2, 4);
        repeat (n)
            send_word(fsu_pkg::OP_READ, clamp_coord(bx + $urandom_range(0, 4) - 2),
                      clamp_coord(by - 1 + $urandom_range(0, 6)), 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 3) == 0)
            send_word(fsu_pkg::OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                      3'($urandom_range(0, 7)));
        if ($urandom_range(0, 2) == 0)
            send_word(fsu_pkg::OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                      3'($urandom_range(0, 7)));
    endtask

    task automatic run_phase(input int n_words, input int sweeps_max);
        int start;
        start = words_sent;
        while (words_sent < start + n_words) begin
            tx_idle = $urandom_range(0, 3) != 0;
            run_scene(sweeps_max);
        end
        drain();
    endtask

    // receiver: random stalls per word, runs with none, and one long hold-off on request
    initial begin : receiver
        int gap;
        int rx_count;
        bit rx_idle;
        m_tready  = 1'b0;
        hold_done = 0;
        rx_count  = 0;
        rx_idle   = 1'b1;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_asked != hold_done) begin
                m_tready = 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                hold_done++;
            end
            if (rx_count % 16 == 0)
                rx_idle = $urandom_range(0, 2) != 0;
            gap = rx_idle ? $urandom_range(0, 13) : 0;
            if (gap != 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
            rx_count++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_MAX) begin
                $display("FAIL falling_sand_grid_update");
                $finish;
            end
        end
    end

    initial begin : stimulus
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = fsu_pkg::OP_WRITE;
        cfg_wr_en  = 1'b0;
        cfg_index  = fsu_pkg::CFG_SOLID;
        cfg_wdata  = '0;
        words_sent = 0;
        hold_asked = 0;
        tx_idle    = 1'b1;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        write_reg(fsu_pkg::CFG_SOLID, fsu_pkg::SOLID_RST);
        write_reg(fsu_pkg::CFG_FLUID, fsu_pkg::FLUID_RST);

        // grain on a grain with both sides open takes the alternating side
        send_word(fsu_pkg::OP_WRITE, 10, 0, MAT_SAND);
        send_word(fsu_pkg::OP_WRITE, 10, 1, MAT_RED_SAND);
        // sand over water swaps
        send_word(fsu_pkg::OP_WRITE, 20, 5, MAT_WATER);
        send_word(fsu_pkg::OP_WRITE, 20, 6, MAT_SAND);
        // left edge, top row: off-grid neighbours act as blockers
        send_word(fsu_pkg::OP_WRITE, 0, 63, MAT_SAND);
        send_word(fsu_pkg::OP_WRITE, 63, 40, MAT_SPARE);
        send_word(fsu_pkg::OP_WRITE, 30, 0, fsu_pkg::CODE_BLOCKER);
        send_word(fsu_pkg::OP_SWEEP, 0, 0, fsu_pkg::CODE_EMPTY);
        send_word(fsu_pkg::OP_READ, 11, 0, fsu_pkg::CODE_EMPTY);
        send_word(fsu_pkg::OP_READ, 20, 5, fsu_pkg::CODE_EMPTY);
        send_word(fsu_pkg::OP_READ, 20, 6, fsu_pkg::CODE_EMPTY);
        send_word(fsu_pkg::OP_READ, 0, 62, fsu_pkg::CODE_EMPTY);
        send_word(fsu_pkg::OP_READ, 63, 40, fsu_pkg::CODE_EMPTY);
        send_word(fsu_pkg::OP_NONE, 63, 63, MAT_SPARE);
        send_word(fsu_pkg::OP_READ, 63, 63, MAT_SPARE);
        send_word(fsu_pkg::OP_WRITE, 63, 63, MAT_SPARE);
        send_word(fsu_pkg::OP_READ, 63, 63, fsu_pkg::CODE_EMPTY);
        send_word(fsu_pkg::OP_WRITE, 0, 0, fsu_pkg::CODE_EMPTY);
        send_word(fsu_pkg::OP_READ, 0, 0, fsu_pkg::CODE_EMPTY);
        send_word(fsu_pkg::OP_SWEEP, 63, 63, MAT_SPARE);
        send_word(fsu_pkg::OP_READ, 10, 0, fsu_pkg::CODE_EMPTY);
        send_word(fsu_pkg::OP_READ, 30, 0, fsu_pkg::CODE_EMPTY);
        drain();

        // long receiver hold-off with back-to-back words
        hold_asked++;
        tx_idle = 1'b0;
        run_scene(1);
        run_scene(1);
        run_phase(12, 2);

        write_reg(fsu_pkg::CFG_SOLID, 8'hFF);
        write_reg(fsu_pkg::CFG_FLUID, 8'h00);
        run_phase(4, 1);

        write_reg(fsu_pkg::CFG_SOLID, 8'h00);
        write_reg(fsu_pkg::CFG_FLUID, 8'hFF);
        run_phase(4, 1);

        write_reg(fsu_pkg::CFG_SOLID, 8'($urandom_range(0, 255)));
        write_reg(fsu_pkg::CFG_FLUID, 8'($urandom_range(0, 255)));
        run_phase(12, 2);

        write_reg(fsu_pkg::CFG_SOLID, 8'hFC);
        write_reg(fsu_pkg::CFG_FLUID, 8'h11);
        run_phase(8, 2);

        if (fail_count == 0)
            $display("PASS falling_sand_grid_update");
        else
            $display("FAIL falling_sand_grid_update");
        $finish;
    end

endmodule
